### hdl/tsj_pkg.sv
// Shared widths and types for the tetrahedron scaled Jacobian pipeline.
package tsj_pkg;

  localparam int COORD_W = 16;
  localparam int EDGE_W  = 17;
  localparam int PROD_W  = 34;
  localparam int CROSS_W = 35;
  localparam int LEN_W   = 34;
  localparam int JW      = 52;
  localparam int JSUM_W  = 54;
  localparam int DIG_W   = 17;
  localparam int DIG_N   = 4;
  localparam int WIDE_W  = DIG_W * DIG_N;
  localparam int DBL_W   = 2 * WIDE_W;
  localparam int PW      = 101;
  localparam int J2W     = 102;
  localparam int RSH     = 31;
  localparam int RW      = J2W + RSH;
  localparam int EW      = 136;
  localparam int WW      = 118;
  localparam int MW      = 15;
  localparam int SJ_W    = 16;
  localparam int SJ_MAX  = 23170;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic        [LEN_W-1:0]   len_t;
  typedef logic signed [JW-1:0]      jac_t;
  typedef logic        [JW-1:0]      ujac_t;
  typedef logic signed [JSUM_W-1:0]  jsum_t;
  typedef logic        [WIDE_W-1:0]  wide_t;
  typedef logic        [DBL_W-1:0]   dbl_t;
  typedef logic        [PW-1:0]      pw_t;
  typedef logic        [J2W-1:0]     j2_t;
  typedef logic        [RW-1:0]      rw_t;
  typedef logic signed [EW-1:0]      ew_t;
  typedef logic signed [WW-1:0]      ww_t;
  typedef logic        [MW-1:0]      mag_t;
  typedef logic signed [SJ_W-1:0]    sj_t;

endpackage

### hdl/tsj_mul.sv
// Pipelined unsigned 68x68 multiplier built from 17-bit partial products.
module tsj_mul (
  input  logic          clk,
  input  logic          en,
  input  tsj_pkg::wide_t a,
  input  tsj_pkg::wide_t b,
  output tsj_pkg::dbl_t  p
);

  localparam int DW = tsj_pkg::DIG_W;
  localparam int DN = tsj_pkg::DIG_N;

  typedef logic [2*DW-1:0] pp_t;
  typedef logic [3*DW-1:0] pr_t;
  typedef logic [5*DW-1:0] row_t;
  typedef logic [6*DW-1:0] half_t;

  pp_t   pp  [DN][DN];
  pr_t   pr  [DN][2];
  row_t  row [DN];
  half_t hv  [2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DN; i++) begin
        for (int j = 0; j < DN; j++) begin
          pp[i][j] <= pp_t'(a[i*DW +: DW]) * pp_t'(b[j*DW +: DW]);
        end
        pr[i][0] <= pr_t'(pp[i][0]) + (pr_t'(pp[i][1]) << DW);
        pr[i][1] <= pr_t'(pp[i][2]) + (pr_t'(pp[i][3]) << DW);
        row[i]   <= row_t'(pr[i][0]) + (row_t'(pr[i][1]) << (2*DW));
      end
      hv[0] <= half_t'(row[0]) + (half_t'(row[1]) << DW);
      hv[1] <= half_t'(row[2]) + (half_t'(row[3]) << DW);
      p     <= tsj_pkg::dbl_t'(hv[0]) + (tsj_pkg::dbl_t'(hv[1]) << (2*DW));
    end
  end

endmodule

### hdl/tsj_geom.sv
// Edge vectors, squared edge lengths and the signed triple product.
module tsj_geom (
  input  logic            clk,
  input  logic            en,
  input  tsj_pkg::coord_t crd [12],
  output tsj_pkg::len_t   len [6],
  output tsj_pkg::jac_t   jac
);

  localparam int EFROM [6] = '{0, 0, 0, 1, 1, 2};
  localparam int ETO   [6] = '{1, 2, 3, 2, 3, 3};

  tsj_pkg::edge_t  edg   [6][3];
  tsj_pkg::edge_t  e01_d [3];
  tsj_pkg::edge_t  e01_q [3];
  tsj_pkg::prod_t  xp    [6];
  tsj_pkg::len_t   sq    [6][3];
  tsj_pkg::cross_t cr    [3];
  tsj_pkg::jac_t   tp    [3];
  tsj_pkg::jsum_t  jsum;

  always_comb begin
    jsum = tsj_pkg::jsum_t'(tp[0]) + tsj_pkg::jsum_t'(tp[1]) + tsj_pkg::jsum_t'(tp[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        for (int c = 0; c < 3; c++) begin
          edg[k][c] <= tsj_pkg::edge_t'(crd[ETO[k]*3 + c])
                     - tsj_pkg::edge_t'(crd[EFROM[k]*3 + c]);
          sq[k][c]  <= tsj_pkg::len_t'(tsj_pkg::prod_t'(edg[k][c])
                                       * tsj_pkg::prod_t'(edg[k][c]));
        end
        len[k] <= sq[k][0] + sq[k][1] + sq[k][2];
      end
      for (int c = 0; c < 3; c++) begin
        e01_d[c] <= edg[0][c];
        e01_q[c] <= e01_d[c];
        tp[c]    <= tsj_pkg::jac_t'(e01_q[c]) * tsj_pkg::jac_t'(cr[c]);
      end
      xp[0] <= tsj_pkg::prod_t'(edg[1][1]) * tsj_pkg::prod_t'(edg[2][2]);
      xp[1] <= tsj_pkg::prod_t'(edg[1][2]) * tsj_pkg::prod_t'(edg[2][1]);
      xp[2] <= tsj_pkg::prod_t'(edg[1][2]) * tsj_pkg::prod_t'(edg[2][0]);
      xp[3] <= tsj_pkg::prod_t'(edg[1][0]) * tsj_pkg::prod_t'(edg[2][2]);
      xp[4] <= tsj_pkg::prod_t'(edg[1][0]) * tsj_pkg::prod_t'(edg[2][1]);
      xp[5] <= tsj_pkg::prod_t'(edg[1][1]) * tsj_pkg::prod_t'(edg[2][0]);
      cr[0] <= tsj_pkg::cross_t'(xp[0]) - tsj_pkg::cross_t'(xp[1]);
      cr[1] <= tsj_pkg::cross_t'(xp[2]) - tsj_pkg::cross_t'(xp[3]);
      cr[2] <= tsj_pkg::cross_t'(xp[4]) - tsj_pkg::cross_t'(xp[5]);
      jac   <= tsj_pkg::jac_t'(jsum[tsj_pkg::JW-1:0]);
    end
  end

endmodule

### hdl/tsj_root.sv
// Bit-per-stage search for the rounded Q1.14 ratio magnitude.
module tsj_root (
  input  logic          clk,
  input  logic          en,
  input  tsj_pkg::pw_t  p,
  input  tsj_pkg::rw_t  r,
  output tsj_pkg::mag_t m
);

  localparam int NB = tsj_pkg::MW;

  tsj_pkg::ew_t  e  [NB+1];
  tsj_pkg::ww_t  w  [NB+1];
  tsj_pkg::pw_t  pq [NB+1];
  tsj_pkg::mag_t x  [NB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      e[0]  <= tsj_pkg::ew_t'(r) - tsj_pkg::ew_t'(p);
      w[0]  <= -tsj_pkg::ww_t'(p);
      pq[0] <= p;
      x[0]  <= '0;
    end
  end

  for (genvar s = 0; s < NB; s++) begin : g_bit
    localparam int B = NB - 1 - s;
    tsj_pkg::ew_t cand;

    always_comb begin
      cand = e[s] - (tsj_pkg::ew_t'(w[s]) <<< (B + 2))
                  - (tsj_pkg::ew_t'(pq[s]) << (2*B + 2));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pq[s+1] <= pq[s];
        if (!cand[tsj_pkg::EW-1]) begin
          e[s+1] <= cand;
          w[s+1] <= w[s] + (tsj_pkg::ww_t'(pq[s]) << (B + 1));
          x[s+1] <= x[s] | (tsj_pkg::mag_t'(1) << B);
        end else begin
          e[s+1] <= e[s];
          w[s+1] <= w[s];
          x[s+1] <= x[s];
        end
      end
    end
  end

  assign m = x[NB];

endmodule

### hdl/tet_scaled_jacobian.sv
// Top level: tetrahedron minimum Jacobian and scaled Jacobian pipeline.
// Throughput: one tetrahedron per cycle while the skid register is empty; all stages advance together.
// A stalled result parks in a skid register; the pipeline holds from the cycle after.
// Reset clears the stage valid bits and the skid flag; data registers are not reset.
module tet_scaled_jacobian (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tsj_pkg::coord_t v0_x,
  input  tsj_pkg::coord_t v0_y,
  input  tsj_pkg::coord_t v0_z,
  input  tsj_pkg::coord_t v1_x,
  input  tsj_pkg::coord_t v1_y,
  input  tsj_pkg::coord_t v1_z,
  input  tsj_pkg::coord_t v2_x,
  input  tsj_pkg::coord_t v2_y,
  input  tsj_pkg::coord_t v2_z,
  input  tsj_pkg::coord_t v3_x,
  input  tsj_pkg::coord_t v3_y,
  input  tsj_pkg::coord_t v3_z,
  output logic            out_valid,
  input  logic            out_ready,
  output tsj_pkg::jac_t   min_jacobian,
  output tsj_pkg::sj_t    scaled_jac,
  output logic            inverted
);

  localparam int NS = 32;
  localparam int VA [4] = '{2, 4, 5, 2};
  localparam int VB [4] = '{0, 3, 3, 5};
  localparam int VC [4] = '{1, 0, 1, 4};

  logic            en;
  logic            vld [1:NS];
  tsj_pkg::coord_t crd [12];
  tsj_pkg::len_t   len [6];
  tsj_pkg::jac_t   jac;
  tsj_pkg::ujac_t  jabs;
  tsj_pkg::jac_t   jp  [6:31];
  tsj_pkg::len_t   lcd [4][5];
  tsj_pkg::dbl_t   abp [4];
  tsj_pkg::dbl_t   abcp [4];
  tsj_pkg::pw_t    pv  [4];
  tsj_pkg::dbl_t   j2w;
  tsj_pkg::j2_t    j2p [11:15];
  tsj_pkg::pw_t    pa;
  tsj_pkg::pw_t    pb;
  tsj_pkg::pw_t    psel;
  tsj_pkg::rw_t    rr;
  tsj_pkg::mag_t   mag;
  tsj_pkg::mag_t   magc;
  logic            pos13;
  logic            pos14;
  tsj_pkg::jac_t   oj;
  tsj_pkg::sj_t    os;
  logic            oinv;
  logic            skid_full;
  tsj_pkg::jac_t   sk_j;
  tsj_pkg::sj_t    sk_s;
  logic            sk_i;

  assign en       = !skid_full;
  assign in_ready = en && !rst;

  assign crd = '{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                 v2_x, v2_y, v2_z, v3_x, v3_y, v3_z};

  tsj_geom u_geom (
    .clk (clk),
    .en  (en),
    .crd (crd),
    .len (len),
    .jac (jac)
  );

  assign jabs = jac[tsj_pkg::JW-1] ? tsj_pkg::ujac_t'(-jac) : tsj_pkg::ujac_t'(jac);

  tsj_mul u_mul_j2 (
    .clk (clk),
    .en  (en),
    .a   (tsj_pkg::wide_t'(jabs)),
    .b   (tsj_pkg::wide_t'(jabs)),
    .p   (j2w)
  );

  for (genvar v = 0; v < 4; v++) begin : g_vtx
    tsj_mul u_mul_ab (
      .clk (clk),
      .en  (en),
      .a   (tsj_pkg::wide_t'(len[VA[v]])),
      .b   (tsj_pkg::wide_t'(len[VB[v]])),
      .p   (abp[v])
    );

    tsj_mul u_mul_abc (
      .clk (clk),
      .en  (en),
      .a   (abp[v][tsj_pkg::WIDE_W-1:0]),
      .b   (tsj_pkg::wide_t'(lcd[v][4])),
      .p   (abcp[v])
    );

    assign pv[v] = abcp[v][tsj_pkg::PW-1:0];
  end

  tsj_root u_root (
    .clk (clk),
    .en  (en),
    .p   (psel),
    .r   (rr),
    .m   (mag)
  );

  assign pos13 = !jp[13][tsj_pkg::JW-1] && (jp[13] != '0);
  assign pos14 = !jp[14][tsj_pkg::JW-1] && (jp[14] != '0);
  assign rr    = tsj_pkg::rw_t'(j2p[15]) << tsj_pkg::RSH;
  assign magc  = (mag > tsj_pkg::mag_t'(tsj_pkg::SJ_MAX)) ?
                 tsj_pkg::mag_t'(tsj_pkg::SJ_MAX) : mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NS; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= in_valid;
      for (int k = 2; k <= NS; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      jp[6] <= jac;
      for (int k = 7; k <= 31; k++) begin
        jp[k] <= jp[k-1];
      end
      for (int v = 0; v < 4; v++) begin
        lcd[v][0] <= len[VC[v]];
        for (int k = 1; k < 5; k++) begin
          lcd[v][k] <= lcd[v][k-1];
        end
      end
      j2p[11] <= j2w[tsj_pkg::J2W-1:0];
      for (int k = 12; k <= 15; k++) begin
        j2p[k] <= j2p[k-1];
      end
      if (pos13) begin
        pa <= (pv[0] > pv[1]) ? pv[0] : pv[1];
        pb <= (pv[2] > pv[3]) ? pv[2] : pv[3];
      end else begin
        pa <= (pv[0] < pv[1]) ? pv[0] : pv[1];
        pb <= (pv[2] < pv[3]) ? pv[2] : pv[3];
      end
      if (pos14) begin
        psel <= (pa > pb) ? pa : pb;
      end else begin
        psel <= (pa < pb) ? pa : pb;
      end
      oj   <= jp[31];
      oinv <= jp[31][tsj_pkg::JW-1] || (jp[31] == '0);
      if (jp[31] == '0) begin
        os <= '0;
      end else if (jp[31][tsj_pkg::JW-1]) begin
        os <= -tsj_pkg::sj_t'(magc);
      end else begin
        os <= tsj_pkg::sj_t'(magc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ready) begin
        skid_full <= 1'b0;
      end
    end else if (vld[NS] && !out_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      sk_j <= oj;
      sk_s <= os;
      sk_i <= oinv;
    end
  end

  assign out_valid    = skid_full || vld[NS];
  assign min_jacobian = skid_full ? sk_j : oj;
  assign scaled_jac   = skid_full ? sk_s : os;
  assign inverted     = skid_full ? sk_i : oinv;

  a_skid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(vld[NS]))
    else $error("skid loaded without a finished result");

  a_inv_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (inverted == (min_jacobian[tsj_pkg::JW-1] || (min_jacobian == '0))))
    else $error("inverted flag disagrees with min_jacobian");

  a_sj_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((scaled_jac <= tsj_pkg::sj_t'(tsj_pkg::SJ_MAX)) &&
                   (scaled_jac >= -tsj_pkg::sj_t'(tsj_pkg::SJ_MAX))))
    else $error("scaled_jac out of range");

  a_sj_sign: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !inverted) |-> !scaled_jac[tsj_pkg::SJ_W-1])
    else $error("positive element with negative scaled_jac");

endmodule
